// ----- rtl/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescaper (UTF-8 in, UTF-16 out).
// Standalone package; imported by the decoder, the queue, the top level and the checker.
`default_nettype none

package jsu_pkg;

	// Status codes carried with each result word
	localparam logic [1:0] ST_UNIT  = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	localparam logic [15:0] REPLACEMENT = 16'hFFFD;
	localparam logic [7:0]  CH_QUOTE    = 8'h22;
	localparam logic [7:0]  CH_BSLASH   = 8'h5C;

	// Result queue geometry
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);
	localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_BODY = 5'b00010,
		PH_ESC  = 5'b00100,
		PH_HEX  = 5'b01000,
		PH_UTF8 = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  pending;
		logic [20:0] accum;
		logic [15:0] hex;
		logic [2:0]  hexcnt;
	} jsu_state_t;

	localparam jsu_state_t IDLE_STATE = '{
		phase:   PH_IDLE,
		pending: 2'd0,
		accum:   21'd0,
		hex:     16'd0,
		hexcnt:  3'd0
	};

	typedef struct packed {
		logic [15:0] code_unit;
		logic [1:0]  status;
		logic        last;
	} jsu_result_t;

	// Results of one accepted byte, handed from the decoder to the queue
	typedef struct packed {
		logic [1:0]  count;
		jsu_result_t r0;
		jsu_result_t r1;
	} jsu_push_t;

endpackage

`default_nettype wire

// ----- rtl/jsu_if.sv -----
// Valid/ready channel interfaces for the byte input and the code-unit output.
// Standalone; no package needed.
`default_nettype none

interface jsu_byte_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] text_byte;

	modport source (output valid, kind, text_byte, input ready);
	modport sink   (input valid, kind, text_byte, output ready);
endinterface

interface jsu_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, code_unit, status, last, input ready);
	modport sink   (input valid, code_unit, status, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/jsu_decode.sv -----
// Parser state register and combinational decode of one input word into 0..2 results.
// Depends on jsu_pkg.
`default_nettype none

module jsu_decode
	import jsu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic       kind,
	input  wire logic [7:0] text_byte,
	output jsu_push_t       push
);

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_N  = 8'h6E;
	localparam logic [7:0] CH_LC_R  = 8'h72;
	localparam logic [7:0] CH_LC_T  = 8'h74;
	localparam logic [7:0] CH_LC_U  = 8'h75;

	typedef struct packed {
		logic        emit;
		logic [15:0] unit;
		logic [1:0]  status;
		jsu_state_t  st;
	} body_t;

	jsu_state_t st_q;
	jsu_state_t nxt;
	jsu_result_t r0, r1;
	logic [1:0] n;

	// Plain string body byte, starting from the given state
	function automatic body_t body_step(jsu_state_t base, logic [7:0] b);
		body_t o;
		o.emit   = 1'b0;
		o.unit   = 16'd0;
		o.status = ST_UNIT;
		o.st     = base;
		if (b == CH_QUOTE) begin
			o.emit   = 1'b1;
			o.status = ST_DONE;
			o.st     = IDLE_STATE;
		end else if (b == CH_BSLASH) begin
			o.st.phase = PH_ESC;
		end else if (!b[7]) begin
			o.emit = 1'b1;
			o.unit = {8'h00, b};
		end else if (b[7:5] == 3'b110) begin
			o.st.accum   = {16'd0, b[4:0]};
			o.st.pending = 2'd1;
			o.st.phase   = PH_UTF8;
		end else if (b[7:4] == 4'b1110) begin
			o.st.accum   = {17'd0, b[3:0]};
			o.st.pending = 2'd2;
			o.st.phase   = PH_UTF8;
		end else if (b[7:3] == 5'b11110) begin
			o.st.accum   = {18'd0, b[2:0]};
			o.st.pending = 2'd3;
			o.st.phase   = PH_UTF8;
		end else begin
			o.emit = 1'b1;
			o.unit = REPLACEMENT;
		end
		return o;
	endfunction

	// {valid, digit}
	function automatic logic [4:0] hex_digit(logic [7:0] b);
		logic [7:0] d;
		d = 8'd0;
		if (b inside {[8'h30:8'h39]}) begin
			d = b - 8'h30;
			return {1'b1, d[3:0]};
		end else if (b inside {[8'h61:8'h66]}) begin
			d = b - 8'h57;
			return {1'b1, d[3:0]};
		end else if (b inside {[8'h41:8'h46]}) begin
			d = b - 8'h37;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	body_t       bs;
	jsu_state_t  base;
	logic [4:0]  hd;
	logic [15:0] hex_new;
	logic [2:0]  hcnt_new;
	logic [20:0] acc_new;
	logic [20:0] v;
	logic [1:0]  pend_new;
	logic [15:0] esc_unit;
	logic        esc_ok;

	always_comb begin
		nxt      = st_q;
		n        = 2'd0;
		r0       = '0;
		r1       = '0;
		base     = st_q;
		base.phase   = PH_BODY;
		base.pending = 2'd0;
		base.accum   = 21'd0;
		bs       = body_step(st_q, text_byte);
		hd       = hex_digit(text_byte);
		hex_new  = {st_q.hex[11:0], hd[3:0]};
		hcnt_new = st_q.hexcnt + 3'd1;
		acc_new  = {st_q.accum[14:0], text_byte[5:0]};
		v        = acc_new - 21'h10000;
		pend_new = st_q.pending - 2'd1;
		esc_unit = 16'd0;
		esc_ok   = 1'b1;

		if (kind) begin
			// End of text: flush an open sequence as U+FFFD, then report error
			if (st_q.phase == PH_UTF8) begin
				r0 = '{code_unit: REPLACEMENT, status: ST_UNIT, last: 1'b0};
				r1 = '{code_unit: 16'd0, status: ST_ERROR, last: 1'b1};
				n  = 2'd2;
			end else begin
				r0 = '{code_unit: 16'd0, status: ST_ERROR, last: 1'b1};
				n  = 2'd1;
			end
			nxt = IDLE_STATE;
		end else begin
			case (st_q.phase)
				PH_BODY: begin
					nxt = bs.st;
					if (bs.emit) begin
						r0 = '{code_unit: bs.unit, status: bs.status, last: 1'b1};
						n  = 2'd1;
					end
				end
				PH_ESC: begin
					case (text_byte)
						CH_QUOTE:  esc_unit = 16'h0022;
						CH_BSLASH: esc_unit = 16'h005C;
						CH_SLASH:  esc_unit = 16'h002F;
						CH_LC_B:   esc_unit = 16'h0008;
						CH_LC_F:   esc_unit = 16'h000C;
						CH_LC_N:   esc_unit = 16'h000A;
						CH_LC_R:   esc_unit = 16'h000D;
						CH_LC_T:   esc_unit = 16'h0009;
						default:   esc_ok   = 1'b0;
					endcase
					if (text_byte == CH_LC_U) begin
						nxt.phase  = PH_HEX;
						nxt.hex    = 16'd0;
						nxt.hexcnt = 3'd0;
					end else if (esc_ok) begin
						r0        = '{code_unit: esc_unit, status: ST_UNIT, last: 1'b1};
						n         = 2'd1;
						nxt.phase = PH_BODY;
					end else begin
						r0  = '{code_unit: 16'd0, status: ST_ERROR, last: 1'b1};
						n   = 2'd1;
						nxt = IDLE_STATE;
					end
				end
				PH_HEX: begin
					if (!hd[4]) begin
						r0  = '{code_unit: 16'd0, status: ST_ERROR, last: 1'b1};
						n   = 2'd1;
						nxt = IDLE_STATE;
					end else if (hcnt_new[2]) begin
						r0         = '{code_unit: hex_new, status: ST_UNIT, last: 1'b1};
						n          = 2'd1;
						nxt.hex    = 16'd0;
						nxt.hexcnt = 3'd0;
						nxt.phase  = PH_BODY;
					end else begin
						nxt.hex    = hex_new;
						nxt.hexcnt = hcnt_new;
					end
				end
				PH_UTF8: begin
					if (text_byte[7:6] == 2'b10) begin
						nxt.pending = pend_new;
						if (pend_new == 2'd0) begin
							nxt.accum = 21'd0;
							nxt.phase = PH_BODY;
							if (acc_new[20:16] == 5'd0) begin
								r0 = '{code_unit: acc_new[15:0], status: ST_UNIT, last: 1'b1};
								n  = 2'd1;
							end else begin
								r0 = '{code_unit: 16'hD800 + {5'd0, v[20:10]},
									status: ST_UNIT, last: 1'b0};
								r1 = '{code_unit: {6'b110111, v[9:0]},
									status: ST_UNIT, last: 1'b1};
								n  = 2'd2;
							end
						end else begin
							nxt.accum = acc_new;
						end
					end else begin
						// Broken sequence: replacement, then rerun the byte as body
						bs  = body_step(base, text_byte);
						nxt = bs.st;
						r0  = '{code_unit: REPLACEMENT, status: ST_UNIT, last: !bs.emit};
						if (bs.emit) begin
							r1 = '{code_unit: bs.unit, status: bs.status, last: 1'b1};
							n  = 2'd2;
						end else begin
							n  = 2'd1;
						end
					end
				end
				default: begin
					if (text_byte == CH_QUOTE) begin
						nxt       = IDLE_STATE;
						nxt.phase = PH_BODY;
					end else begin
						r0  = '{code_unit: 16'd0, status: ST_ERROR, last: 1'b1};
						n   = 2'd1;
						nxt = IDLE_STATE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE_STATE;
		end else if (accept) begin
			st_q <= nxt;
		end
	end

	assign push.count = accept ? n : 2'd0;
	assign push.r0    = r0;
	assign push.r1    = r1;

endmodule

`default_nettype wire

// ----- rtl/jsu_fifo.sv -----
// Small result queue: takes up to two words per cycle, hands out one while units.ready is high.
// Depends on jsu_pkg and jsu_unit_if.
`default_nettype none

module jsu_fifo
	import jsu_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  jsu_push_t   push,
	output logic        space,
	jsu_unit_if.source  units
);

	jsu_result_t          mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0]     wr_q;
	logic [RQ_AW-1:0]     rd_q;
	logic [RQ_CW-1:0]     cnt_q;
	logic                 pop;
	jsu_result_t          head;

	assign pop   = units.valid & units.ready;
	// Keep room for the worst case of one input word
	assign space = cnt_q <= RQ_CW'(RQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + RQ_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RQ_AW'(push.count);
			rd_q  <= rd_q + RQ_AW'(pop);
			cnt_q <= cnt_q + RQ_CW'(push.count) - RQ_CW'(pop);
		end
	end

	assign head            = mem_q[rd_q];
	assign units.valid     = cnt_q != '0;
	assign units.code_unit = head.code_unit;
	assign units.status    = head.status;
	assign units.last      = head.last;

endmodule

`default_nettype wire

// ----- rtl/json_string_utf8_to_utf16.sv -----
// Top level of the JSON string unescaper: byte channel in, UTF-16 code-unit channel out.
// Depends on jsu_pkg, jsu_if, jsu_decode and jsu_fifo.
//
// Usage:
//   bytes : one word per JSON text byte (kind = 0) or an end-of-text marker (kind = 1).
//           Taken at a rising edge with bytes.valid and bytes.ready both high.
//   units : result words. status 0 carries a UTF-16 code unit, status 1 reports a
//           closed string, status 2 a parse error. last marks the final word caused
//           by one input word; a surrogate pair or a replacement plus a reparsed byte
//           gives two words, escape prefixes and open UTF-8 sequences give none.
// Results go into the queue as their input word is taken and appear on units in order.
// Throughput: one input word per cycle while bytes.ready is high. The decoder works
//   on the byte in the cycle it is taken and writes its results into a four-word queue;
//   bytes.ready drops while the queue has fewer than two free words, so a run of
//   two-word results is held to the output rate of one word per cycle at most.
// Reset: arst_n clears the parser to idle (waiting for an opening quote) and empties
//   the queue; no result is pending after reset.
// Stall: while units.ready is low the head word holds; the queue absorbs up to two
//   more input words before bytes.ready falls.
`default_nettype none

module json_string_utf8_to_utf16
	import jsu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	jsu_byte_if.sink   bytes,
	jsu_unit_if.source units
);

	logic      accept;
	logic      space;
	jsu_push_t push;

	// Take a word only when the queue can hold its worst-case two results
	assign bytes.ready = space;
	assign accept      = bytes.valid & space;

	// Decode the byte and advance the parser state
	jsu_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (bytes.kind),
		.text_byte (bytes.text_byte),
		.push      (push)
	);

	// Buffer results and hand them out one per cycle while units.ready is high
	jsu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.space  (space),
		.units  (units)
	);

endmodule

`default_nettype wire

// ----- rtl/jsu_checker.sv -----
// Port-level checks for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg.
`default_nettype none

module jsu_checker
	import jsu_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_kind,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_code_unit,
	input wire logic [1:0]  out_status,
	input wire logic        out_last
);

	// Stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_code_unit)
			&& $stable(out_status) && $stable(out_last))
		else $error("stalled result word changed");

	// Done and error always close the results of their input word
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_UNIT |-> out_last)
		else $error("done or error word not marked last");

	// Only unit words carry a code unit; status 3 never appears
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_UNIT |-> out_code_unit == 16'd0
			&& (out_status == ST_DONE || out_status == ST_ERROR))
		else $error("bad status or payload on non-unit word");

	// End of text always yields a result on the next cycle
	a_eot: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_kind |=> out_valid)
		else $error("end of text gave no result");

endmodule

bind json_string_utf8_to_utf16 jsu_checker u_jsu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (bytes.valid),
	.in_ready      (bytes.ready),
	.in_kind       (bytes.kind),
	.out_valid     (units.valid),
	.out_ready     (units.ready),
	.out_code_unit (units.code_unit),
	.out_status    (units.status),
	.out_last      (units.last)
);

`default_nettype wire
